@@ hw/rtl/tmsf_pkg.sv @@
// Shared types, constants and width helpers for the trimmed-mean sample filter.
`timescale 1ns / 1ps
`default_nettype none
package tmsf_pkg;

   // Field widths of the ports
   localparam int SAMPLE_W  = 12;
   localparam int REF_W     = 13;
   localparam int UV_W      = 23;
   localparam int TSUM_W    = 15;

   // Converter resolution: code full scale is 2^SAMPLE_BITS
   localparam int SAMPLE_BITS = 12;

   // Microvolts per millivolt
   localparam int UV_SCALE = 1000;
   localparam int SCALE_W  = 10;

   // Quotient bits resolved per divider cycle
   localparam int DIV_RADIX_BITS = 4;

   localparam logic [REF_W-1:0] REF_RESET = 13'd3300;

   localparam int DEF_GROUP_SIZE = 7;
   localparam int DEF_TRIM       = 1;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIM,
      ST_MUL_REF,
      ST_MUL_SCALE,
      ST_DIV,
      ST_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;     // take the request sample into the sorted buffer
      logic trim_step;  // remove one trimmed entry from the running total
      logic mul_ref;    // total times reference
      logic mul_scale;  // times 1000, scale down, load divider
      logic div_step;   // one radix step of the divider
      logic out_load;   // move the result into the response register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic group_last; // buffer holds all but one sample of the group
      logic out_full;   // response register still holds a result
   } status_type;

   // Running total width for a group
   function automatic int sum_width(input int group_size);
      return SAMPLE_BITS + $clog2(group_size);
   endfunction

   // Samples left after the trim, zero when nothing survives
   function automatic int kept_count(input int group_size, input int trim);
      return (group_size > 2 * trim) ? group_size - 2 * trim : 0;
   endfunction

   // Dividend width after the scale-down shift
   function automatic int dividend_width(input int group_size);
      return sum_width(group_size) + REF_W + SCALE_W - SAMPLE_BITS;
   endfunction

   // Divider cycles for one result
   function automatic int div_steps(input int group_size);
      return (dividend_width(group_size) + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tmsf_ctrl.sv @@
// Sequencer for the trimmed-mean sample filter: handshake, trim sweep, scaling and divide.
`timescale 1ns / 1ps
`default_nettype none
module tmsf_ctrl #(
   parameter int GROUP_SIZE = tmsf_pkg::DEF_GROUP_SIZE,
   parameter int TRIM       = tmsf_pkg::DEF_TRIM
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire tmsf_pkg::status_type           status,
   output tmsf_pkg::cmd_type                   cmd,
   output logic [$clog2(GROUP_SIZE)-1:0]       trim_idx
);
   import tmsf_pkg::*;

   localparam int IDX_W     = $clog2(GROUP_SIZE);
   localparam int KEPT      = kept_count(GROUP_SIZE, TRIM);
   localparam int SKIP_OFS  = (KEPT > 0) ? GROUP_SIZE - 2 * TRIM : 0;
   localparam int DIV_STEPS = div_steps(GROUP_SIZE);
   localparam int CNT_MAX   = (2 * TRIM > DIV_STEPS) ? 2 * TRIM : DIV_STEPS;
   localparam int CNT_W     = $clog2(CNT_MAX + 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // State and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Trim sweep visits the lowest TRIM entries, then the highest TRIM entries
   always_comb begin
      if (cnt_ff < CNT_W'(TRIM)) begin
         trim_idx = IDX_W'(cnt_ff);
      end else begin
         trim_idx = IDX_W'(cnt_ff) + IDX_W'(SKIP_OFS);
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               if (status.group_last) begin
                  if (KEPT == 0) begin
                     state_in = ST_DONE;
                  end else if (TRIM == 0) begin
                     state_in = ST_MUL_REF;
                  end else begin
                     state_in = ST_TRIM;
                  end
               end
            end
         end
         ST_TRIM: begin
            cmd.trim_step = 1'b1;
            cnt_in        = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(2 * TRIM - 1)) begin
               state_in = ST_MUL_REF;
            end
         end
         ST_MUL_REF: begin
            cmd.mul_ref = 1'b1;
            state_in    = ST_MUL_SCALE;
         end
         ST_MUL_SCALE: begin
            cmd.mul_scale = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the response register to drain
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A completed group blocks new requests for the next cycle
   a_group_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.group_last) |=> !req_ready)
      else $error("request taken right after a group completed");

   // Commands are mutually exclusive
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

endmodule
`default_nettype wire

@@ hw/rtl/tmsf_datapath.sv @@
// Datapath: sorted sample buffer, running total, scaling multipliers, divider, response register.
`timescale 1ns / 1ps
`default_nettype none
module tmsf_datapath #(
   parameter int GROUP_SIZE = tmsf_pkg::DEF_GROUP_SIZE,
   parameter int TRIM       = tmsf_pkg::DEF_TRIM
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tmsf_pkg::cmd_type                  cmd,
   input  wire logic [$clog2(GROUP_SIZE)-1:0]      trim_idx,
   output tmsf_pkg::status_type                    status,
   input  wire logic [tmsf_pkg::SAMPLE_W-1:0]      req_sample,
   input  wire logic                               csr_wr_en,
   input  wire logic [tmsf_pkg::REF_W-1:0]         csr_wr_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [tmsf_pkg::UV_W-1:0]               rsp_voltage_uv,
   output logic [tmsf_pkg::TSUM_W-1:0]             rsp_trimmed_sum
);
   import tmsf_pkg::*;

   localparam int IDX_W     = $clog2(GROUP_SIZE);
   localparam int SUM_W     = sum_width(GROUP_SIZE);
   localparam int P1_W      = SUM_W + REF_W;
   localparam int P2_W      = P1_W + SCALE_W;
   localparam int DIV_W     = div_steps(GROUP_SIZE) * DIV_RADIX_BITS;
   localparam int KEPT      = kept_count(GROUP_SIZE, TRIM);
   localparam int KEPT_DIV  = (KEPT > 0) ? KEPT : 1;
   localparam int KEPT_W    = $clog2(KEPT_DIV + 1);

   logic [SAMPLE_BITS-1:0]  sample_x;
   logic [SAMPLE_BITS-1:0]  buf_ff [GROUP_SIZE];
   logic [SAMPLE_BITS-1:0]  buf_in [GROUP_SIZE];
   logic [GROUP_SIZE-1:0]   gt;
   logic [IDX_W-1:0]        fill_ff, fill_in;
   logic [SUM_W-1:0]        total_ff, total_in;
   logic [REF_W-1:0]        ref_ff;
   logic [P1_W-1:0]         p1_ff;
   logic [P2_W-1:0]         p2;
   logic [DIV_W-1:0]        div_ff, div_in;
   logic [KEPT_W-1:0]       rem_ff, rem_in;
   logic                    rsp_valid_ff;
   logic [UV_W-1:0]         uv_ff;
   logic [TSUM_W-1:0]       tsum_ff;

   assign sample_x = req_sample[SAMPLE_BITS-1:0];

   // Insertion into the sorted buffer: empty slots count as larger than any sample
   for (genvar i = 0; i < GROUP_SIZE; i++) begin : g_ins
      assign gt[i] = (IDX_W'(i) >= fill_ff) || (buf_ff[i] > sample_x);
      if (i == 0) begin : g_first
         assign buf_in[i] = gt[i] ? sample_x : buf_ff[i];
      end else begin : g_rest
         assign buf_in[i] = !gt[i]    ? buf_ff[i]   :
                            gt[i - 1] ? buf_ff[i-1] : sample_x;
      end
   end

   // Buffer contents need no reset: each slot is written before it is read
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         buf_ff <= buf_in;
      end
   end

   // Fill count
   assign status.group_last = (fill_ff == IDX_W'(GROUP_SIZE - 1));
   assign fill_in = status.group_last ? '0 : fill_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.accept) begin
         fill_ff <= fill_in;
      end
   end

   // Running total: add on each request, subtract trimmed entries in the sweep
   always_comb begin
      total_in = total_ff;
      if (cmd.accept) begin
         total_in = ((fill_ff == '0) ? '0 : total_ff) + SUM_W'(sample_x);
      end else if (cmd.trim_step) begin
         total_in = total_ff - SUM_W'(buf_ff[trim_idx]);
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   // Reference register
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= REF_RESET;
      end else if (csr_wr_en) begin
         ref_ff <= csr_wr_data;
      end
   end

   // Scaling: total * ref, then * 1000 and drop the converter resolution
   assign p2 = P2_W'(p1_ff) * P2_W'(UV_SCALE);

   always_ff @(posedge clock) begin
      if (cmd.mul_ref) begin
         p1_ff <= P1_W'(total_ff) * P1_W'(ref_ff);
      end
   end

   // Restoring divider by the kept count, DIV_RADIX_BITS quotient bits per cycle.
   // Dividend bits leave at the top, quotient bits enter at the bottom.
   always_comb begin
      logic [KEPT_W:0]    r;
      logic [DIV_W-1:0]   d;
      r = {1'b0, rem_ff};
      d = div_ff;
      for (int s = 0; s < DIV_RADIX_BITS; s++) begin
         r = {r[KEPT_W-1:0], d[DIV_W-1]};
         d = {d[DIV_W-2:0], 1'b0};
         if (r >= (KEPT_W + 1)'(KEPT_DIV)) begin
            r    = r - (KEPT_W + 1)'(KEPT_DIV);
            d[0] = 1'b1;
         end
      end
      div_in = d;
      rem_in = r[KEPT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_scale) begin
         div_ff <= DIV_W'(p2 >> SAMPLE_BITS);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         div_ff <= div_in;
         rem_ff <= rem_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         uv_ff   <= (KEPT == 0) ? '0 : UV_W'(div_ff);
         tsum_ff <= (KEPT == 0) ? '0 : TSUM_W'(total_ff);
      end
   end

   assign status.out_full  = rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_voltage_uv   = uv_ff;
   assign rsp_trimmed_sum  = tsum_ff;

   // A result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff)
      else $error("response register overwritten");

   // The last sample of a group empties the buffer
   a_group_wrap: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.group_last) |=> (fill_ff == '0))
      else $error("fill count did not wrap at group end");

endmodule
`default_nettype wire

@@ hw/rtl/trimmed_mean_sample_filter_unit.sv @@
// Top level of the trimmed-mean sample filter: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Collects GROUP_SIZE converter samples, keeping them sorted as they arrive, then drops
// the TRIM lowest and TRIM highest and returns the mean of the rest in microvolts
// (sum * ref_millivolts * 1000 / (kept * 4096), truncated) together with the raw kept sum.
// While a group fills, each offered sample request is taken. The request that completes a
// group starts the result sequence, during which no request is taken: a trim sweep over
// the sorted buffer (skipped when TRIM is 0), a multiply by ref_millivolts, a multiply by
// 1000 with the scale-down, the radix-16 restoring divide by the kept count, and a load of
// the response register; with nothing kept, only the load. The response register is
// separate, so sample requests keep flowing while a result waits to be taken; the load
// stalls only while the previous result has still not been taken.
// ref_millivolts resets to 3300.
module trimmed_mean_sample_filter_unit #(
   parameter int GROUP_SIZE = tmsf_pkg::DEF_GROUP_SIZE,
   parameter int TRIM       = tmsf_pkg::DEF_TRIM
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [tmsf_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [tmsf_pkg::UV_W-1:0]             rsp_voltage_uv,
   output logic [tmsf_pkg::TSUM_W-1:0]           rsp_trimmed_sum,
   input  wire logic                             csr_wr_en,
   input  wire logic [tmsf_pkg::REF_W-1:0]       csr_wr_data
);
   import tmsf_pkg::*;

   cmd_type                          cmd;
   status_type                       status;
   logic [$clog2(GROUP_SIZE)-1:0]    trim_idx;

   tmsf_ctrl #(
      .GROUP_SIZE (GROUP_SIZE),
      .TRIM       (TRIM)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd),
      .trim_idx   (trim_idx)
   );

   tmsf_datapath #(
      .GROUP_SIZE (GROUP_SIZE),
      .TRIM       (TRIM)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .trim_idx        (trim_idx),
      .status          (status),
      .req_sample      (req_sample),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_voltage_uv  (rsp_voltage_uv),
      .rsp_trimmed_sum (rsp_trimmed_sum)
   );

endmodule
`default_nettype wire

@@ verif/tmsf_result_checker.sv @@
// Checker for the trimmed-mean sample filter: predicts each group's mean and compares results.
`timescale 1ns / 1ps
module tmsf_result_checker #(
   parameter int GROUP_SIZE = tmsf_pkg::DEF_GROUP_SIZE,
   parameter int TRIM       = tmsf_pkg::DEF_TRIM
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [tmsf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [tmsf_pkg::UV_W-1:0]     rsp_voltage_uv,
   input  logic [tmsf_pkg::TSUM_W-1:0]   rsp_trimmed_sum,
   input  logic                          csr_wr_en,
   input  logic [tmsf_pkg::REF_W-1:0]    csr_wr_data,
   output int                            mismatch_count,
   output int                            results_pending
);
   import tmsf_pkg::*;

   typedef struct packed {
      logic [UV_W-1:0]   voltage_uv;
      logic [TSUM_W-1:0] trimmed_sum;
   } mean_result_type;

   // Mirror of the block's state
   logic [SAMPLE_W-1:0] group_samples [GROUP_SIZE];
   int                  samples_held;
   logic [REF_W-1:0]    ref_mv;
   mean_result_type     expected_means [$];

   initial mismatch_count = 0;
   initial results_pending = 0;

   // Sort a copy of the group, drop the trimmed ends, sum the rest and scale to microvolts
   function automatic mean_result_type trimmed_mean();
      logic [SAMPLE_W-1:0] ordered [GROUP_SIZE];
      logic [SAMPLE_W-1:0] key;
      logic [63:0]         total;
      logic [63:0]         kept;
      logic [63:0]         scaled;
      mean_result_type     result;
      int                  j;
      total = '0;
      kept  = '0;
      scaled = '0;
      for (int i = 0; i < GROUP_SIZE; i++) ordered[i] = group_samples[i];
      for (int i = 1; i < GROUP_SIZE; i++) begin
         key = ordered[i];
         j = i - 1;
         while (j >= 0 && ordered[j] > key) begin
            ordered[j + 1] = ordered[j];
            j--;
         end
         ordered[j + 1] = key;
      end
      for (int i = TRIM; i < GROUP_SIZE - TRIM; i++) begin
         total += 64'(ordered[i]);
         kept++;
      end
      // nothing survives the trim: mean is zero
      if (kept != 0)
         scaled = (total * 64'(ref_mv) * 64'(UV_SCALE)) / (kept << SAMPLE_BITS);
      result.voltage_uv  = scaled[UV_W-1:0];
      result.trimmed_sum = total[TSUM_W-1:0];
      return result;
   endfunction

   // Track config writes, predict on each request, check each response
   always @(posedge clock) begin
      mean_result_type want;
      if (reset) begin
         samples_held = 0;
         ref_mv = REF_RESET;
         expected_means.delete();
      end else begin
         if (csr_wr_en) ref_mv = csr_wr_data;
         if (req_valid && req_ready) begin
            group_samples[samples_held] = req_sample;
            samples_held++;
            if (samples_held == GROUP_SIZE) begin
               samples_held = 0;
               expected_means.push_back(trimmed_mean());
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_means.size() == 0) begin
               $error("unexpected result: voltage_uv %0d trimmed_sum %0d",
                      rsp_voltage_uv, rsp_trimmed_sum);
               mismatch_count++;
            end else begin
               want = expected_means.pop_front();
               if (rsp_voltage_uv !== want.voltage_uv) begin
                  $error("voltage_uv mismatch: expected %0d, actual %0d",
                         want.voltage_uv, rsp_voltage_uv);
                  mismatch_count++;
               end
               if (rsp_trimmed_sum !== want.trimmed_sum) begin
                  $error("trimmed_sum mismatch: expected %0d, actual %0d",
                         want.trimmed_sum, rsp_trimmed_sum);
                  mismatch_count++;
               end
            end
         end
      end
      results_pending <= expected_means.size();
   end

endmodule

@@ verif/trimmed_mean_sample_filter_unit_tb.sv @@
// Testbench top for the trimmed-mean sample filter: stimulus, response pacing and verdict.
`timescale 1ns / 1ps
module trimmed_mean_sample_filter_unit_tb;
   import tmsf_pkg::*;

   localparam int RESET_CYCLES     = 5;
   localparam int SETTLE_CYCLES    = 30;
   localparam int RSP_HOLD_CYCLES  = 400;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int PHASES           = 12;
   localparam int GROUPS_PER_PHASE = 22;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = '0;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
   localparam logic [REF_W-1:0]    REF_ZERO    = '0;
   localparam logic [REF_W-1:0]    REF_FULL    = '1;
   localparam logic [REF_W-1:0]    REF_LOW_MV  = 13'd1000;
   localparam logic [REF_W-1:0]    REF_HIGH_MV = 13'd5000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_sample;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [UV_W-1:0]     rsp_voltage_uv;
   logic [TSUM_W-1:0]   rsp_trimmed_sum;
   logic                csr_wr_en;
   logic [REF_W-1:0]    csr_wr_data;

   int mismatch_count;
   int results_pending;
   int stall_cycles = 0;
   bit sender_steady = 1'b0;
   bit rsp_hold_request = 1'b0;

   trimmed_mean_sample_filter_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_voltage_uv (rsp_voltage_uv),
      .rsp_trimmed_sum(rsp_trimmed_sum),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   tmsf_result_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_voltage_uv (rsp_voltage_uv),
      .rsp_trimmed_sum(rsp_trimmed_sum),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .results_pending(results_pending)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one sample request and hold it until taken
   task automatic offer_sample(input logic [SAMPLE_W-1:0] value);
      int gap;
      gap = sender_steady ? 0 : idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering, wait for every predicted result, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reference(input logic [REF_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One full group with a randomly chosen shape
   task automatic send_random_group();
      logic [SAMPLE_W-1:0] level;
      int                  style;
      style = $urandom_range(0, 9);
      level = SAMPLE_W'($urandom_range(0, 4095));
      for (int k = 0; k < DEF_GROUP_SIZE; k++) begin
         case (style)
            0: offer_sample(level);                                  // all ties
            1: begin                                                 // rails mixed in
               case ($urandom_range(0, 2))
                  0: offer_sample(SAMPLE_MIN);
                  1: offer_sample(SAMPLE_MAX);
                  default: offer_sample(SAMPLE_W'($urandom_range(0, 4095)));
               endcase
            end
            2: offer_sample(SAMPLE_W'(level + $urandom_range(0, 3))); // tight cluster
            default: offer_sample(SAMPLE_W'($urandom_range(0, 4095)));
         endcase
      end
   endtask

   // Response side: random ready stretches, plus one long hold on request
   initial begin
      int stretch;
      rsp_ready <= 1'b0;
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
         repeat (stretch) @(posedge clock);
         stretch = idle_gap();
         if (stretch != 0) begin
            rsp_ready <= 1'b0;
            repeat (stretch) @(posedge clock);
         end
      end
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Main stimulus
   initial begin
      logic [REF_W-1:0] ref_choice;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_sample  <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed groups at the reset reference: full scale, zero, outliers at both rails
      for (int k = 0; k < DEF_GROUP_SIZE; k++) offer_sample(SAMPLE_MAX);
      for (int k = 0; k < DEF_GROUP_SIZE; k++) offer_sample(SAMPLE_MIN);
      offer_sample(SAMPLE_MAX);
      offer_sample(SAMPLE_MIN);
      offer_sample(12'd2048);
      offer_sample(12'd1);
      offer_sample(12'd4094);
      offer_sample(12'd2047);
      offer_sample(12'd2049);
      drain_results();

      // Random phases, each under its own reference setting
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: ref_choice = REF_FULL;
            1: ref_choice = REF_ZERO;
            2: ref_choice = REF_LOW_MV;
            3: ref_choice = REF_HIGH_MV;
            4: ref_choice = REF_RESET;
            default: ref_choice = REF_W'($urandom_range(0, 8191));
         endcase
         write_reference(ref_choice);
         sender_steady = (phase == 2) || (phase == 5);
         // back-pressure test: receiver stalls while samples keep coming
         if (phase == 2) rsp_hold_request = 1'b1;
         for (int g = 0; g < GROUPS_PER_PHASE; g++) send_random_group();
         drain_results();
      end

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
